// File: rtl/json_token_child_walker_top_assert.svh
// assertion macros for the json token child walker
`ifndef JSON_TOKEN_CHILD_WALKER_TOP_ASSERT_SVH
`define JSON_TOKEN_CHILD_WALKER_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define JTCW_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
	else $error("json token child walker: assertion failed");
`define JTCW_ASSERT_RST(lbl, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("json token child walker: reset assertion failed");
`else
`define JTCW_ASSERT(lbl, prop)
`define JTCW_ASSERT_RST(lbl, prop)
`endif

`endif

// File: rtl/jtcw_pkg.sv
// shared types and constants for the json token child walker
`timescale 1ns / 1ps
package jtcw_pkg;

	localparam int POS_W = 16;
	localparam int IDX_W = 7;
	localparam int VAL_W = 8;
	localparam int OP_W  = 3;

	localparam logic [OP_W-1:0] OP_LOAD      = 3'd0;
	localparam logic [OP_W-1:0] OP_ARR_COUNT = 3'd1;
	localparam logic [OP_W-1:0] OP_ARR_NTH   = 3'd2;
	localparam logic [OP_W-1:0] OP_OBJ_COUNT = 3'd3;
	localparam logic [OP_W-1:0] OP_OBJ_KEY   = 3'd4;
	localparam logic [OP_W-1:0] OP_OBJ_VAL   = 3'd5;

	localparam logic ST_OK      = 1'b0;
	localparam logic ST_NO_DATA = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]  opcode;
		logic [IDX_W-1:0] load_slot;
		logic [POS_W-1:0] span_start;
		logic [POS_W-1:0] span_end;
		logic [IDX_W-1:0] container_index;
		logic [IDX_W-1:0] child_pos;
	} in_word_t;

	typedef struct packed {
		logic             status;
		logic [VAL_W-1:0] result_value;
	} out_word_t;

	typedef struct packed {
		logic [POS_W-1:0] hi;
		logic [POS_W-1:0] lo;
	} span_t;

	typedef struct packed {
		logic past_end;
		logic child;
		logic hit;
	} step_flags_t;

endpackage

// File: rtl/jtcw_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
module jtcw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/jtcw_step.sv
// shared compare unit: judges one walked token against the container
`timescale 1ns / 1ps
module jtcw_step import jtcw_pkg::*; #(
	parameter int KW = 8
) (
	input  logic [POS_W-1:0] tok_lo,
	input  logic [POS_W-1:0] tok_hi,
	input  logic [POS_W-1:0] next_hi,
	input  logic [POS_W-1:0] cend,
	input  logic [POS_W-1:0] prev,
	input  logic [KW-1:0]    kids,
	input  logic [IDX_W-1:0] elem,
	input  logic             is_obj,
	input  logic             want_on,
	output step_flags_t      flags,
	output logic [POS_W-1:0] prev_nxt,
	output logic [KW-1:0]    kids_nxt
);

	localparam int EW = (KW > IDX_W) ? KW : IDX_W;

	logic past_end;
	logic child;

	assign past_end = tok_lo > cend;
	assign child    = !past_end && (tok_lo > prev);

	assign flags.past_end = past_end;
	assign flags.child    = child;
	assign flags.hit      = child && want_on && (EW'(kids) == EW'(elem));

	// object child ends where its value ends
	assign prev_nxt = is_obj ? next_hi : tok_hi;
	assign kids_nxt = kids + KW'(1);

endmodule

// File: rtl/json_token_child_walker_top.sv
// json token child walker: span table, query sequencer and result register
//
//   port        dir  width      role
//   start/cmd   in   in_word_t  command word, taken when start and not busy
//   done/rsp    out  out_word_t result word, one cycle, strobed by done
//   cfg_we      in   8 bit data token_count register write, no wait
//
// loads and rejected queries are answered straight from idle; the result shows the next cycle
// a query reads one table entry per cycle through the single ram read port,
//   going from idle through a head state that reads the container entry to a
//   walk state over the tokens; busy stays high until the result cycle
// reset clears control and token_count; table entries are undefined until loaded
// the receiver cannot stall; each result is strobed by done for exactly one cycle
`timescale 1ns / 1ps
module json_token_child_walker_top import jtcw_pkg::*; #(
	parameter int TOKEN_SLOTS = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  in_word_t         cmd,
	output logic             done,
	output out_word_t        rsp,
	input  logic             cfg_we,
	input  logic [VAL_W-1:0] cfg_wdata
);

	`include "json_token_child_walker_top_assert.svh"

	localparam int IW = $clog2(TOKEN_SLOTS);
	localparam int CW = $clog2(TOKEN_SLOTS + 1);
	localparam int LW = ((CW > VAL_W) ? CW : VAL_W) + 1;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_HEAD = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;

	logic [1:0]       state_q;
	logic [VAL_W-1:0] token_count_q;
	logic [CW-1:0]    n_q;
	logic [OP_W-1:0]  op_q;
	logic [IDX_W-1:0] elem_q;
	logic [CW-1:0]    data_idx_q;
	logic [CW-1:0]    kids_q;
	logic [POS_W-1:0] cend_q;
	logic [POS_W-1:0] prev_q;
	span_t            cur_q;
	logic             cur_v_q;
	logic             done_q;
	out_word_t        rsp_q;

	logic [LW-1:0]    slots_l;
	logic [LW-1:0]    tc_l;
	logic [LW-1:0]    n_l;
	logic             acc;
	logic             is_query;
	logic             c_ok;
	logic             slot_ok;
	logic             ram_we;
	logic [IW-1:0]    raddr;
	logic [31:0]      rdata;
	span_t            rspan;
	logic [CW-1:0]    nxt_idx;
	logic             more;
	logic [POS_W-1:0] next_hi;
	logic             is_obj;
	logic             want_on;
	step_flags_t      flags;
	logic [POS_W-1:0] prev_nxt;
	logic [CW-1:0]    kids_nxt;
	logic             fin;
	logic             fin_found;
	logic [CW-1:0]    fin_cnt;
	logic [CW-1:0]    hit_idx;
	out_word_t        fin_rsp;

	assign slots_l = LW'(TOKEN_SLOTS);
	assign tc_l    = LW'(token_count_q);
	assign n_l     = (tc_l > slots_l) ? slots_l : tc_l;

	assign busy     = state_q != S_IDLE;
	assign acc      = start && !busy;
	assign is_query = cmd.opcode == OP_ARR_COUNT || cmd.opcode == OP_ARR_NTH ||
		cmd.opcode == OP_OBJ_COUNT || cmd.opcode == OP_OBJ_KEY ||
		cmd.opcode == OP_OBJ_VAL;
	assign c_ok     = LW'(cmd.container_index) < n_l;
	assign slot_ok  = LW'(cmd.load_slot) < slots_l;
	assign ram_we   = acc && cmd.opcode == OP_LOAD && slot_ok;

	assign nxt_idx = data_idx_q + CW'(1);
	assign raddr   = busy ? nxt_idx[IW-1:0] : IW'(cmd.container_index);

	jtcw_ram #(
		.WIDTH(32),
		.DEPTH(TOKEN_SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(IW'(cmd.load_slot)),
		.wdata({cmd.span_end, cmd.span_start}),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign rspan   = span_t'(rdata);
	assign more    = data_idx_q < n_q;
	assign next_hi = more ? rspan.hi : cur_q.hi;
	assign is_obj  = op_q == OP_OBJ_COUNT || op_q == OP_OBJ_KEY || op_q == OP_OBJ_VAL;
	assign want_on = op_q == OP_ARR_NTH || op_q == OP_OBJ_KEY || op_q == OP_OBJ_VAL;
	assign hit_idx = data_idx_q - CW'(1);

	jtcw_step #(
		.KW(CW)
	) u_step (
		.tok_lo  (cur_q.lo),
		.tok_hi  (cur_q.hi),
		.next_hi (next_hi),
		.cend    (cend_q),
		.prev    (prev_q),
		.kids    (kids_q),
		.elem    (elem_q),
		.is_obj  (is_obj),
		.want_on (want_on),
		.flags   (flags),
		.prev_nxt(prev_nxt),
		.kids_nxt(kids_nxt)
	);

	// end of walk and its outcome
	always_comb begin
		fin       = 1'b0;
		fin_found = 1'b0;
		fin_cnt   = kids_q;
		if (state_q == S_WALK) begin
			if (!cur_v_q) begin
				fin = !more;
			end else if (flags.past_end) begin
				fin = 1'b1;
			end else if (flags.hit) begin
				fin       = 1'b1;
				fin_found = 1'b1;
			end else begin
				fin     = !more;
				fin_cnt = flags.child ? kids_nxt : kids_q;
			end
		end
	end

	always_comb begin
		fin_rsp.status       = ST_NO_DATA;
		fin_rsp.result_value = '0;
		unique case (op_q)
			OP_ARR_COUNT, OP_OBJ_COUNT: begin
				fin_rsp.status       = ST_OK;
				fin_rsp.result_value = VAL_W'(fin_cnt);
			end
			OP_ARR_NTH, OP_OBJ_KEY: begin
				if (fin_found) begin
					fin_rsp.status       = ST_OK;
					fin_rsp.result_value = VAL_W'(hit_idx);
				end
			end
			OP_OBJ_VAL: begin
				if (fin_found) begin
					fin_rsp.status       = ST_OK;
					fin_rsp.result_value = VAL_W'(hit_idx) + VAL_W'(1);
				end
			end
			default: begin
				fin_rsp.status       = ST_NO_DATA;
				fin_rsp.result_value = '0;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			done_q        <= 1'b0;
			token_count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				token_count_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (is_query && c_ok) begin
							state_q <= S_HEAD;
						end else begin
							done_q <= 1'b1;
						end
					end
				end
				S_HEAD: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (fin) begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// walk datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (acc) begin
					op_q       <= cmd.opcode;
					elem_q     <= cmd.child_pos;
					n_q        <= CW'(n_l);
					data_idx_q <= CW'(cmd.container_index);
					kids_q     <= '0;
					cur_v_q    <= 1'b0;
					rsp_q.result_value <= '0;
					rsp_q.status <= (cmd.opcode == OP_LOAD) ? ST_OK : ST_NO_DATA;
				end
			end
			S_HEAD: begin
				cend_q     <= rspan.hi;
				prev_q     <= rspan.lo;
				data_idx_q <= nxt_idx;
			end
			S_WALK: begin
				if (fin) begin
					rsp_q <= fin_rsp;
				end else begin
					if (cur_v_q && flags.child) begin
						prev_q <= prev_nxt;
						kids_q <= kids_nxt;
					end
					cur_q      <= rspan;
					cur_v_q    <= 1'b1;
					data_idx_q <= nxt_idx;
				end
			end
			default: begin
				cur_v_q <= 1'b0;
			end
		endcase
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	`JTCW_ASSERT(a_head_to_walk, state_q == S_HEAD |=> state_q == S_WALK)
	`JTCW_ASSERT(a_walk_bound, state_q == S_WALK |-> data_idx_q <= n_q)
	`JTCW_ASSERT(a_kids_bound, state_q == S_WALK |-> kids_q < data_idx_q)
	`JTCW_ASSERT(a_fin_done, (state_q == S_WALK && fin) |=> (done && state_q == S_IDLE))
	`JTCW_ASSERT_RST(a_rst_idle, !arst_n |-> (state_q == S_IDLE && !done))

endmodule
